// ===== src/lsil_pkg.sv =====
package lsil_pkg;

    localparam int MAX_LINES  = 1024;
    localparam int POS_BITS   = 20;
    localparam int IDX_W      = $clog2(MAX_LINES);
    localparam int CNT_W      = $clog2(MAX_LINES + 1);
    localparam int OFFSET_W   = 24;
    localparam int LINE_NUM_W = 25;
    localparam int COLUMN_W   = 20;
    localparam int STATUS_W   = 2;
    localparam int ACTION_W   = 2;
    localparam int CHAR_W     = 21;
    localparam int QPOS_W     = 20;

    localparam int FQ_DEPTH   = 4;
    localparam int FQ_AW      = $clog2(FQ_DEPTH);
    localparam int FQ_CW      = $clog2(FQ_DEPTH + 1);

    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_CR = 21'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF = 21'd10;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic                is_cr;
        logic                is_lf;
        logic [QPOS_W-1:0]   qpos;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_STEP,
        BS_CMP
    } t_bstate;

endpackage

// ===== src/lsil_front.sv =====
module lsil_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [lsil_pkg::ACTION_W-1:0]      i_action,
    input  logic [lsil_pkg::CHAR_W-1:0]        i_text_char,
    input  logic [lsil_pkg::QPOS_W-1:0]        i_query_pos,
    output logic                               o_full,
    output lsil_pkg::t_front_out               o_front,
    input  logic                               i_take
);

    lsil_pkg::t_item                   r_queue [lsil_pkg::FQ_DEPTH];
    logic [lsil_pkg::FQ_AW-1:0]        r_head;
    logic [lsil_pkg::FQ_AW-1:0]        r_tail;
    logic [lsil_pkg::FQ_CW-1:0]        r_count;
    lsil_pkg::t_item                   w_item;
    logic                              w_keep;
    logic                              w_enq;
    logic                              w_deq;

    // Classify: turn the character into terminator flags, drop unused actions.
    always_comb begin
        w_item.is_cr = (i_text_char == lsil_pkg::CHAR_CR);
        w_item.is_lf = (i_text_char == lsil_pkg::CHAR_LF);
        w_item.qpos  = i_query_pos;
        w_item.op    = lsil_pkg::OP_PUSH;
        w_keep       = 1'b1;
        unique case (i_action)
            lsil_pkg::ACT_PUSH:  w_item.op = lsil_pkg::OP_PUSH;
            lsil_pkg::ACT_QUERY: w_item.op = lsil_pkg::OP_QUERY;
            lsil_pkg::ACT_CLEAR: w_item.op = lsil_pkg::OP_CLEAR;
            default:             w_keep    = 1'b0;
        endcase
    end

    assign o_full        = (r_count == lsil_pkg::FQ_CW'(lsil_pkg::FQ_DEPTH));
    assign w_enq         = i_push && !o_full && w_keep;
    assign w_deq         = i_take && (r_count != '0);
    assign o_front.valid = (r_count != '0);
    assign o_front.item  = r_queue[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_enq) begin
                r_tail <= r_tail + 1'b1;
            end
            if (w_deq) begin
                r_head <= r_head + 1'b1;
            end
            if (w_enq && !w_deq) begin
                r_count <= r_count + 1'b1;
            end else if (!w_enq && w_deq) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enq) begin
            r_queue[r_tail] <= w_item;
        end
    end

endmodule

// ===== src/lsil_back.sv =====
module lsil_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsil_pkg::t_front_out                i_front,
    output logic                                o_take,
    input  logic                                i_cfg_valid,
    input  logic [lsil_pkg::OFFSET_W-1:0]       i_cfg_line_offset,
    input  logic                                i_pop,
    output logic                                o_out_valid,
    output logic [lsil_pkg::LINE_NUM_W-1:0]     o_line_number,
    output logic [lsil_pkg::COLUMN_W-1:0]       o_column,
    output logic [lsil_pkg::STATUS_W-1:0]       o_status
);

    logic [lsil_pkg::POS_BITS-1:0]   r_mem [lsil_pkg::MAX_LINES];
    logic [lsil_pkg::POS_BITS-1:0]   r_rd_data;

    lsil_pkg::t_bstate               r_state, n_state;
    logic [lsil_pkg::CNT_W-1:0]      r_total, n_total;
    logic [lsil_pkg::POS_BITS-1:0]   r_text_pos, n_text_pos;
    logic [lsil_pkg::POS_BITS-1:0]   r_pending, n_pending;
    logic                            r_start_pend, n_start_pend;
    logic                            r_last_cr, n_last_cr;
    logic                            r_ovf, n_ovf;
    logic [lsil_pkg::OFFSET_W-1:0]   r_offset;

    logic [lsil_pkg::CNT_W-1:0]      r_lo, n_lo;
    logic [lsil_pkg::CNT_W-1:0]      r_hi, n_hi;
    logic [lsil_pkg::CNT_W-1:0]      r_mid, n_mid;
    logic [lsil_pkg::POS_BITS-1:0]   r_lo_val, n_lo_val;
    logic [lsil_pkg::QPOS_W-1:0]     r_qpos, n_qpos;

    logic                            r_out_valid, n_out_valid;
    logic [lsil_pkg::LINE_NUM_W-1:0] r_line_number, n_line_number;
    logic [lsil_pkg::COLUMN_W-1:0]   r_column, n_column;
    logic [lsil_pkg::STATUS_W-1:0]   r_status, n_status;

    logic                            w_wr_en;
    logic [lsil_pkg::IDX_W-1:0]      w_wr_addr;
    logic                            w_rd_en;
    logic [lsil_pkg::POS_BITS-1:0]   w_pos_adv;
    logic [lsil_pkg::CNT_W-1:0]      w_span;
    logic                            w_out_free;
    lsil_pkg::t_item                 w_item;

    assign w_item     = i_front.item;
    assign w_pos_adv  = (r_text_pos == '1) ? r_text_pos : r_text_pos + 1'b1;
    assign w_span     = r_hi - r_lo;
    assign w_out_free = !r_out_valid || i_pop;
    assign w_wr_addr  = r_total[lsil_pkg::IDX_W-1:0];
    assign o_take     = i_front.valid && (r_state == lsil_pkg::BS_IDLE);

    always_comb begin
        n_state       = r_state;
        n_total       = r_total;
        n_text_pos    = r_text_pos;
        n_pending     = r_pending;
        n_start_pend  = r_start_pend;
        n_last_cr     = r_last_cr;
        n_ovf         = r_ovf;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_lo_val      = r_lo_val;
        n_qpos        = r_qpos;
        n_out_valid   = r_out_valid && !i_pop;
        n_line_number = r_line_number;
        n_column      = r_column;
        n_status      = r_status;
        w_wr_en       = 1'b0;
        w_rd_en       = 1'b0;
        unique case (r_state)
            lsil_pkg::BS_IDLE: begin
                if (i_front.valid) begin
                    unique case (w_item.op)
                        lsil_pkg::OP_PUSH: begin
                            if (w_item.is_lf && r_last_cr) begin
                                n_last_cr  = 1'b0;
                                n_text_pos = w_pos_adv;
                                n_pending  = w_pos_adv;
                            end else begin
                                if (r_start_pend) begin
                                    if (r_total < lsil_pkg::CNT_W'(lsil_pkg::MAX_LINES)) begin
                                        w_wr_en = 1'b1;
                                        n_total = r_total + 1'b1;
                                    end else begin
                                        n_ovf = 1'b1;
                                    end
                                end
                                n_text_pos = w_pos_adv;
                                if (w_item.is_cr || w_item.is_lf) begin
                                    n_start_pend = 1'b1;
                                    n_last_cr    = w_item.is_cr;
                                    n_pending    = w_pos_adv;
                                end else begin
                                    n_start_pend = 1'b0;
                                    n_last_cr    = 1'b0;
                                end
                            end
                        end
                        lsil_pkg::OP_QUERY: begin
                            n_lo     = '0;
                            n_hi     = r_total;
                            n_lo_val = '0;
                            n_qpos   = w_item.qpos;
                            n_state  = lsil_pkg::BS_STEP;
                        end
                        lsil_pkg::OP_CLEAR: begin
                            n_total      = '0;
                            n_text_pos   = '0;
                            n_pending    = '0;
                            n_start_pend = 1'b1;
                            n_last_cr    = 1'b0;
                            n_ovf        = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            lsil_pkg::BS_STEP: begin
                if (w_span > lsil_pkg::CNT_W'(1)) begin
                    // Halve the window: read the middle entry.
                    n_mid   = r_lo + (w_span >> 1);
                    w_rd_en = 1'b1;
                    n_state = lsil_pkg::BS_CMP;
                end else if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_line_number = lsil_pkg::LINE_NUM_W'(r_lo)
                                  + lsil_pkg::LINE_NUM_W'(r_offset);
                    n_column      = r_qpos - r_lo_val;
                    if (r_total == '0) begin
                        n_line_number = '0;
                        n_column      = '0;
                        n_status      = lsil_pkg::STATUS_EMPTY;
                    end else if (r_ovf) begin
                        n_status = lsil_pkg::STATUS_OVERFLOW;
                    end else begin
                        n_status = lsil_pkg::STATUS_OK;
                    end
                    n_state = lsil_pkg::BS_IDLE;
                end
            end
            lsil_pkg::BS_CMP: begin
                if (r_rd_data > r_qpos) begin
                    n_hi = r_mid;
                end else begin
                    n_lo     = r_mid;
                    n_lo_val = r_rd_data;
                end
                n_state = lsil_pkg::BS_STEP;
            end
            default: n_state = lsil_pkg::BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsil_pkg::BS_IDLE;
            r_total      <= '0;
            r_text_pos   <= '0;
            r_pending    <= '0;
            r_start_pend <= 1'b1;
            r_last_cr    <= 1'b0;
            r_ovf        <= 1'b0;
            r_offset     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_total      <= n_total;
            r_text_pos   <= n_text_pos;
            r_pending    <= n_pending;
            r_start_pend <= n_start_pend;
            r_last_cr    <= n_last_cr;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid) begin
                r_offset <= i_cfg_line_offset;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_mid         <= n_mid;
        r_lo_val      <= n_lo_val;
        r_qpos        <= n_qpos;
        r_line_number <= n_line_number;
        r_column      <= n_column;
        r_status      <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= r_pending;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[n_mid[lsil_pkg::IDX_W-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_number = r_line_number;
    assign o_column      = r_column;
    assign o_status      = r_status;

endmodule

// ===== src/line_start_index_and_lookup.sv =====
// Character push and clear: one transaction per cycle sustained while no query is
//   being searched; an item waits in the registered input queue before the executor.
// Query: the executor runs a binary search loop, each step passing through a STEP and
//   a CMP state around the line-start RAM's registered read port.
// Reset (i_rst_n low, synchronous): empty index, text position 0, line offset 0,
//   both queues empty. The RAM is not swept; only entries below the line count are read.
module line_start_index_and_lookup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input transaction channel
    input  logic                               push,
    output logic                               full,
    input  logic [lsil_pkg::ACTION_W-1:0]      i_action,
    input  logic [lsil_pkg::CHAR_W-1:0]        i_text_char,
    input  logic [lsil_pkg::QPOS_W-1:0]        i_query_pos,
    // result transaction channel
    output logic                               empty,
    input  logic                               pop,
    output logic [lsil_pkg::LINE_NUM_W-1:0]    o_line_number,
    output logic [lsil_pkg::COLUMN_W-1:0]      o_column,
    output logic [lsil_pkg::STATUS_W-1:0]      o_status,
    // line offset register write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsil_pkg::OFFSET_W-1:0]      i_cfg_line_offset
);

    lsil_pkg::t_front_out w_front;
    logic                 w_take;
    logic                 w_out_valid;

    // Front end: classify each transaction and hold it in a short queue, so the
    // source keeps pushing characters while a query is being searched.
    lsil_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_action    (i_action),
        .i_text_char (i_text_char),
        .i_query_pos (i_query_pos),
        .o_full      (full),
        .o_front     (w_front),
        .i_take      (w_take)
    );

    // Back end: track line starts, run the search, hold the result register.
    // Pushes and clears keep draining while a finished result waits for pop.
    lsil_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_front           (w_front),
        .o_take            (w_take),
        .i_cfg_valid       (i_cfg_valid && o_cfg_ready),
        .i_cfg_line_offset (i_cfg_line_offset),
        .i_pop             (pop),
        .o_out_valid       (w_out_valid),
        .o_line_number     (o_line_number),
        .o_column          (o_column),
        .o_status          (o_status)
    );

    // The offset register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign empty       = !w_out_valid;

endmodule

// ===== src/lsil_checker.sv =====
module lsil_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [lsil_pkg::LINE_NUM_W-1:0]    o_line_number,
    input  logic [lsil_pkg::COLUMN_W-1:0]      o_column,
    input  logic [lsil_pkg::STATUS_W-1:0]      o_status
);

    // Reset drops any waiting result.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // Only the three defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == lsil_pkg::STATUS_OK || o_status == lsil_pkg::STATUS_EMPTY
                    || o_status == lsil_pkg::STATUS_OVERFLOW))
        else $error("undefined status code");

    // An empty-index answer carries zero line and column, whatever the offset.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == lsil_pkg::STATUS_EMPTY) |-> (o_line_number == '0 && o_column == '0))
        else $error("empty-index answer not zero");

    // A result not popped holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_line_number) && $stable(o_column)
                              && $stable(o_status)))
        else $error("waiting result changed");

endmodule

bind line_start_index_and_lookup lsil_checker u_lsil_checker (.*);

// ===== tb/line_start_index_and_lookup_checker.sv =====
module line_start_index_and_lookup_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic                                i_full,
    input  logic [lsil_pkg::ACTION_W-1:0]       i_action,
    input  logic [lsil_pkg::CHAR_W-1:0]         i_text_char,
    input  logic [lsil_pkg::QPOS_W-1:0]         i_query_pos,
    input  logic                                i_empty,
    input  logic                                i_pop,
    input  logic [lsil_pkg::LINE_NUM_W-1:0]     i_line_number,
    input  logic [lsil_pkg::COLUMN_W-1:0]       i_column,
    input  logic [lsil_pkg::STATUS_W-1:0]       i_status,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [lsil_pkg::OFFSET_W-1:0]       i_cfg_line_offset,
    output int unsigned                         o_mismatch_count,
    output int unsigned                         o_answers_waiting,
    output int unsigned                         o_answers_checked,
    output int unsigned                         o_empty_answers,
    output int unsigned                         o_overflow_answers
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lsil_pkg::LINE_NUM_W-1:0] line_number;
        logic [lsil_pkg::COLUMN_W-1:0]   column;
        logic [lsil_pkg::STATUS_W-1:0]   status;
    } t_answer;

    // shadow copy of the index
    logic [lsil_pkg::POS_BITS-1:0] line_start [lsil_pkg::MAX_LINES];
    int unsigned                   line_count;
    logic [lsil_pkg::POS_BITS-1:0] text_pos;
    logic [lsil_pkg::POS_BITS-1:0] next_start;
    bit                            awaiting_start;
    bit                            after_cr;
    bit                            overflow_seen;
    logic [lsil_pkg::OFFSET_W-1:0] offset_reg;

    t_answer     pending_answers [$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned empty_seen = 0;
    int unsigned overflow_answers = 0;

    function void wipe_index();
        line_count     = 0;
        text_pos       = '0;
        next_start     = '0;
        awaiting_start = 1'b1;
        after_cr       = 1'b0;
        overflow_seen  = 1'b0;
    endfunction

    function void step_position();
        if (text_pos != '1)
            text_pos = text_pos + 1'b1;
    endfunction

    function void index_char(logic [lsil_pkg::CHAR_W-1:0] ch);
        bit is_cr;
        bit is_lf;
        is_cr = (ch == lsil_pkg::CHAR_CR);
        is_lf = (ch == lsil_pkg::CHAR_LF);
        // LF closing a CR LF pair only moves the position and the next line start
        if (is_lf && after_cr) begin
            after_cr = 1'b0;
            step_position();
            next_start = text_pos;
            return;
        end
        if (awaiting_start) begin
            if (line_count < lsil_pkg::MAX_LINES) begin
                line_start[line_count] = next_start;
                line_count++;
            end else begin
                overflow_seen = 1'b1;
            end
        end
        step_position();
        if (is_cr || is_lf) begin
            awaiting_start = 1'b1;
            after_cr       = is_cr;
            next_start     = text_pos;
        end else begin
            awaiting_start = 1'b0;
            after_cr       = 1'b0;
        end
    endfunction

    function automatic t_answer locate_line(logic [lsil_pkg::QPOS_W-1:0] pos);
        t_answer     ans;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        if (line_count == 0) begin
            ans.line_number = '0;
            ans.column      = '0;
            ans.status      = lsil_pkg::STATUS_EMPTY;
            return ans;
        end
        lo = 0;
        hi = line_count;
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (line_start[mid] > pos)
                hi = mid;
            else
                lo = mid;
        end
        ans.line_number = lsil_pkg::LINE_NUM_W'(lo) + lsil_pkg::LINE_NUM_W'(offset_reg);
        ans.column      = pos - line_start[lo];
        ans.status      = overflow_seen ? lsil_pkg::STATUS_OVERFLOW : lsil_pkg::STATUS_OK;
        return ans;
    endfunction

    function void note_mismatch(string field, logic [31:0] want_val, logic [31:0] got_val);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_val,
                 got_val);
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            wipe_index();
            offset_reg = '0;
            pending_answers.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                offset_reg = i_cfg_line_offset;

            // check the outgoing answer before taking this edge's input
            if (i_pop && !i_empty) begin
                if (pending_answers.size() == 0) begin
                    note_mismatch("unexpected answer, line_number", '0, i_line_number);
                end else begin
                    want = pending_answers.pop_front();
                    checked++;
                    if (want.status == lsil_pkg::STATUS_EMPTY)
                        empty_seen++;
                    if (want.status == lsil_pkg::STATUS_OVERFLOW)
                        overflow_answers++;
                    if (i_line_number !== want.line_number)
                        note_mismatch("line_number", want.line_number, i_line_number);
                    if (i_column !== want.column)
                        note_mismatch("column", want.column, i_column);
                    if (i_status !== want.status)
                        note_mismatch("status", want.status, i_status);
                end
            end

            if (i_push && !i_full) begin
                case (i_action)
                    lsil_pkg::ACT_PUSH:  index_char(i_text_char);
                    lsil_pkg::ACT_QUERY: pending_answers.push_back(locate_line(i_query_pos));
                    lsil_pkg::ACT_CLEAR: wipe_index();
                    default:   ;
                endcase
            end
        end
        o_mismatch_count   <= mismatches;
        o_answers_waiting  <= pending_answers.size();
        o_answers_checked  <= checked;
        o_empty_answers    <= empty_seen;
        o_overflow_answers <= overflow_answers;
    end

endmodule

// ===== tb/line_start_index_and_lookup_tb.sv =====
module line_start_index_and_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // action code the block must ignore
    localparam logic [lsil_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam int unsigned CYCLE_LIMIT = 400_000;
    // cycles to hold after the last answer: covers a full search plus the input queue
    localparam int unsigned SETTLE_CYCLES = 48;
    // line ends needed to push the line table past its capacity
    localparam int unsigned OVERFLOW_ENDS = lsil_pkg::MAX_LINES + 16;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            push;
    logic                            full;
    logic [lsil_pkg::ACTION_W-1:0]   action;
    logic [lsil_pkg::CHAR_W-1:0]     text_char;
    logic [lsil_pkg::QPOS_W-1:0]     query_pos;
    logic                            empty;
    logic                            pop;
    logic [lsil_pkg::LINE_NUM_W-1:0] line_number;
    logic [lsil_pkg::COLUMN_W-1:0]   column;
    logic [lsil_pkg::STATUS_W-1:0]   status;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [lsil_pkg::OFFSET_W-1:0]   cfg_line_offset;

    int unsigned mismatch_count;
    int unsigned answers_waiting;
    int unsigned answers_checked;
    int unsigned empty_answers;
    int unsigned overflow_answers;

    // stimulus bookkeeping; shapes the traffic, never used for checking
    bit          bursts_enabled = 1'b1;
    bit          prev_was_cr = 1'b0;
    int unsigned chars_since_clear = 0;
    int unsigned items_sent = 0;
    int unsigned queries_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    line_start_index_and_lookup dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .push              (push),
        .full              (full),
        .i_action          (action),
        .i_text_char       (text_char),
        .i_query_pos       (query_pos),
        .empty             (empty),
        .pop               (pop),
        .o_line_number     (line_number),
        .o_column          (column),
        .o_status          (status),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_line_offset (cfg_line_offset)
    );

    line_start_index_and_lookup_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_push             (push),
        .i_full             (full),
        .i_action           (action),
        .i_text_char        (text_char),
        .i_query_pos        (query_pos),
        .i_empty            (empty),
        .i_pop              (pop),
        .i_line_number      (line_number),
        .i_column           (column),
        .i_status           (status),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_line_offset  (cfg_line_offset),
        .o_mismatch_count   (mismatch_count),
        .o_answers_waiting  (answers_waiting),
        .o_answers_checked  (answers_checked),
        .o_empty_answers    (empty_answers),
        .o_overflow_answers (overflow_answers)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d answers still expected", $time,
                     cycle_count, answers_waiting);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: take answers whenever offered, but stall in random bursts while
    // bursts are enabled. Exactly one assignment to pop per edge.
    always @(posedge clk) begin
        if (!rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (bursts_enabled && $urandom_range(0, 11) == 0) begin
            pop        <= 1'b0;
            stall_left <= $urandom_range(0, 10);
        end else begin
            pop <= 1'b1;
        end
    end

    // Offer one input transaction and hold it until the block takes it. Returns at
    // the accepting edge, so the next call can drive new data in the same step and
    // keep push high for back-to-back transactions.
    task automatic send(input logic [lsil_pkg::ACTION_W-1:0] act,
                        input logic [lsil_pkg::CHAR_W-1:0] ch,
                        input logic [lsil_pkg::QPOS_W-1:0] qpos);
        int unsigned gap;
        if (bursts_enabled && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        action    <= act;
        text_char <= ch;
        query_pos <= qpos;
        @(posedge clk);
        while (full) @(posedge clk);

        if (act != ACT_UNUSED)
            items_sent++;
        case (act)
            lsil_pkg::ACT_PUSH: begin
                chars_since_clear++;
                prev_was_cr = (ch == lsil_pkg::CHAR_CR);
            end
            lsil_pkg::ACT_QUERY: queries_sent++;
            lsil_pkg::ACT_CLEAR: begin
                chars_since_clear = 0;
                prev_was_cr       = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Spare fields carry random bits; the block must ignore them.
    task automatic send_char(input logic [lsil_pkg::CHAR_W-1:0] ch);
        send(lsil_pkg::ACT_PUSH, ch, lsil_pkg::QPOS_W'($urandom()));
    endtask

    task automatic send_query(input logic [lsil_pkg::QPOS_W-1:0] qpos);
        send(lsil_pkg::ACT_QUERY, lsil_pkg::CHAR_W'($urandom()), qpos);
    endtask

    task automatic send_clear();
        send(lsil_pkg::ACT_CLEAR, lsil_pkg::CHAR_W'($urandom()),
             lsil_pkg::QPOS_W'($urandom()));
    endtask

    // Drop push and hold until every expected answer is back.
    task automatic wait_for_answers();
        push <= 1'b0;
        @(posedge clk);
        while (answers_waiting != 0) @(posedge clk);
    endtask

    // Drain, then let any trailing character or clear work its way through before
    // the offset register is touched.
    task automatic write_offset(input logic [lsil_pkg::OFFSET_W-1:0] value);
        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid       <= 1'b1;
        cfg_line_offset <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly positions inside the text seen so far, plus the range ends and noise.
    function automatic logic [lsil_pkg::QPOS_W-1:0] pick_query_pos();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(0, 99);
        span = (chars_since_clear + 2 > 20'hFFFFF) ? 20'hFFFFF : chars_since_clear + 2;
        if (roll < 70)
            return lsil_pkg::QPOS_W'($urandom_range(0, span));
        else if (roll < 85)
            return lsil_pkg::QPOS_W'($urandom());
        else if (roll < 93)
            return '0;
        else
            return '1;
    endfunction

    function automatic logic [lsil_pkg::CHAR_W-1:0] pick_plain_char();
        if ($urandom_range(0, 99) < 60)
            return lsil_pkg::CHAR_W'($urandom_range(32, 126));
        else
            return lsil_pkg::CHAR_W'($urandom_range(0, 21'h10FFFF));
    endfunction

    // Random text with queries mixed in. In line-heavy mode nearly every character
    // is a terminator and clears are left out, so the line table fills up; the phase
    // keeps going until enough lines have been closed. Unused-action noise is sent
    // on top of the item count.
    task automatic random_text(input int unsigned n_items, input bit line_heavy,
                               input int unsigned min_line_ends);
        int unsigned sent;
        int unsigned line_ends;
        int unsigned roll;
        int unsigned pick;
        sent      = 0;
        line_ends = 0;
        while (sent < n_items || line_ends < min_line_ends) begin
            if (bursts_enabled && $urandom_range(0, 149) == 0)
                wait_for_answers();
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send(ACT_UNUSED, lsil_pkg::CHAR_W'($urandom()),
                     lsil_pkg::QPOS_W'($urandom()));
            end else begin
                sent++;
                if (roll < (line_heavy ? 13 : 33)) begin
                    send_query(pick_query_pos());
                end else if (!line_heavy && roll < 35) begin
                    send_clear();
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < (line_heavy ? 10 : 60)) begin
                        send_char(pick_plain_char());
                    end else if (pick < (line_heavy ? 60 : 75)) begin
                        // a lone LF right after a CR only completes the pair
                        if (!prev_was_cr)
                            line_ends++;
                        send_char(lsil_pkg::CHAR_LF);
                    end else if (pick < (line_heavy ? 80 : 88)) begin
                        line_ends++;
                        send_char(lsil_pkg::CHAR_CR);
                    end else begin
                        line_ends++;
                        send_char(lsil_pkg::CHAR_CR);
                        send_char(lsil_pkg::CHAR_LF);
                    end
                end
            end
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        push            <= 1'b0;
        action          <= lsil_pkg::ACT_PUSH;
        text_char       <= '0;
        query_pos       <= '0;
        cfg_valid       <= 1'b0;
        cfg_line_offset <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, every terminator form, code point and position
        // extremes, the ignored action, and clear.
        write_offset('0);
        send_query(20'd0);
        send_char(lsil_pkg::CHAR_W'(97));
        send_query(20'd0);
        send_char(lsil_pkg::CHAR_CR);
        send_char(lsil_pkg::CHAR_LF);
        send_char(lsil_pkg::CHAR_LF);
        send_char(lsil_pkg::CHAR_CR);
        send_char(lsil_pkg::CHAR_CR);
        send_char(21'h10FFFF);
        send_char(21'h0FFFFF);
        send_char('0);
        send_query(20'd5);
        send_query('1);
        send_query(20'd3);
        send(ACT_UNUSED, '1, '1);
        send_char(lsil_pkg::CHAR_LF);
        send_query(20'd9);
        send_clear();
        send_query(20'd100);
        send_char(lsil_pkg::CHAR_LF);
        send_query(20'd0);
        send_char(lsil_pkg::CHAR_CR);
        send_query(20'd1);
        send_char(lsil_pkg::CHAR_W'(122));
        send_query(20'd1);

        // Largest offset, ordinary text.
        write_offset('1);
        random_text(120, 1'b0, 0);

        // Terminator-heavy text until the line table overflows.
        write_offset(lsil_pkg::OFFSET_W'($urandom()));
        random_text(1200, 1'b1, OVERFLOW_ENDS);

        write_offset(lsil_pkg::OFFSET_W'($urandom()));
        random_text(60, 1'b0, 0);

        // Last part: no idling on either side.
        write_offset(lsil_pkg::OFFSET_W'($urandom()));
        bursts_enabled = 1'b0;
        random_text(100, 1'b0, 0);

        wait_for_answers();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d items with %0d queries and %0d answers checked, offsets 0 to max",
                 items_sent, queries_sent, answers_checked);
        $display("Answers on empty table: %0d, after table overflow: %0d",
                 empty_answers, overflow_answers);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
